// ===== design/lbt_pkg.sv =====
`default_nettype none

package lbt_pkg;

  localparam int unsigned LED_W   = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MAX_CHANNELS = 16;

  localparam logic [CNT_W-1:0] FOREVER = 16'hffff;

  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_TIMED     = 2'd1;
  localparam logic [1:0] MODE_BLINK_ON  = 2'd2;
  localparam logic [1:0] MODE_BLINK_OFF = 2'd3;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SET_ALL = 2'd1;
  localparam logic [1:0] KIND_PROGRAM = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic             lit;
    logic [CNT_W-1:0] on_limit;
    logic [CNT_W-1:0] off_limit;
    logic [CNT_W-1:0] on_count;
    logic [CNT_W-1:0] off_count;
  } chan_t;

endpackage

`default_nettype wire

// ===== design/lbt_step.sv =====
`default_nettype none

module lbt_step (
  input  wire lbt_pkg::chan_t cur,
  output lbt_pkg::chan_t      nxt,
  output logic                hit
);
  import lbt_pkg::*;

  logic             active;
  logic             use_off;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] inc;
  logic             reached;

  // One comparator and one incrementer serve whichever counter the phase uses.
  assign use_off = (cur.mode == MODE_BLINK_OFF);
  assign cnt     = use_off ? cur.off_count : cur.on_count;
  assign lim     = use_off ? cur.off_limit : cur.on_limit;
  assign reached = (cnt >= lim);
  assign inc     = cnt + CNT_W'(1);

  always_comb begin
    case (cur.mode)
      MODE_TIMED:     active = cur.lit && (cur.on_limit != FOREVER);
      MODE_BLINK_ON:  active = 1'b1;
      MODE_BLINK_OFF: active = 1'b1;
      default:        active = 1'b0;
    endcase
  end

  assign hit = active && reached;

  always_comb begin
    nxt = cur;
    if (active) begin
      if (use_off) begin
        nxt.off_count = reached ? '0 : inc;
      end else begin
        nxt.on_count = reached ? '0 : inc;
      end
      if (reached) begin
        case (cur.mode)
          MODE_TIMED: begin
            nxt.mode = MODE_IDLE;
            nxt.lit  = 1'b0;
          end
          MODE_BLINK_ON: begin
            nxt.mode = MODE_BLINK_OFF;
            nxt.lit  = 1'b0;
          end
          MODE_BLINK_OFF: begin
            nxt.mode = MODE_BLINK_ON;
            nxt.lit  = 1'b1;
          end
          default: begin
            nxt.mode = cur.mode;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/led_blink_timer_controller_unit.sv =====
`default_nettype none

// Channel   Handshake              Payload
// request   in_valid / in_ready    kind, channel, mode, lit_level, on_period,
//                                  off_period, all_bitmap
// result    out_valid / out_ready  led_bitmap
//
// A tick request walks the channels one per cycle through the shared step unit,
// and produces a result only when at least one channel's step hit its limit.
// Set-all and in-range program requests go straight to the finishing state; an out-of-range program is dropped.
// The block takes a new request only when the sequencer is idle.
// A finished result waits in the output register; a following result waits
// until that register has been taken.
// Reset is synchronous and clears every channel to idle and the pattern to dark.
module led_blink_timer_controller_unit #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [1:0]                 kind,
  input  wire  [3:0]                 channel,
  input  wire  [1:0]                 mode,
  input  wire                        lit_level,
  input  wire  [lbt_pkg::CNT_W-1:0]  on_period,
  input  wire  [lbt_pkg::CNT_W-1:0]  off_period,
  input  wire  [lbt_pkg::LED_W-1:0]  all_bitmap,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [lbt_pkg::LED_W-1:0]  led_bitmap
);
  import lbt_pkg::*;

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_CHANNELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [IDX_W-1:0] idx;
  logic             any_hit;
  logic [LED_W-1:0] pattern;
  chan_t            chans [NUM_CHANNELS];

  chan_t            step_nxt;
  logic             step_hit;
  logic             ch_ok;
  logic             load_out;

  lbt_step u_step (
    .cur (chans[idx]),
    .nxt (step_nxt),
    .hit (step_hit)
  );

  assign in_ready = (state == ST_IDLE);
  assign ch_ok    = ({1'b0, channel} < 5'(NUM_CHANNELS));
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      any_hit   <= 1'b0;
      pattern   <= '1;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chans[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (kind)
              KIND_TICK: begin
                state   <= ST_WALK;
                idx     <= '0;
                any_hit <= 1'b0;
              end
              KIND_SET_ALL: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                  chans[i].mode     <= MODE_TIMED;
                  chans[i].on_limit <= FOREVER;
                  chans[i].lit      <= ~all_bitmap[i];
                end
                pattern <= all_bitmap;
                state   <= ST_DONE;
              end
              KIND_PROGRAM: begin
                if (ch_ok) begin
                  chans[channel[IDX_W-1:0]] <= '{mode: mode, lit: lit_level,
                                                 on_limit: on_period,
                                                 off_limit: off_period,
                                                 on_count: '0, off_count: '0};
                  pattern[channel] <= ~lit_level;
                  state            <= ST_DONE;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_WALK: begin
          chans[idx] <= step_nxt;
          if (step_hit) begin
            pattern[4'(idx)] <= ~step_nxt.lit;
          end
          any_hit <= any_hit | step_hit;
          if (idx == LAST) begin
            state <= (any_hit || step_hit) ? ST_DONE : ST_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      led_bitmap <= pattern;
    end
  end

  a_tick_starts_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_TICK) |=> (state == ST_WALK) && (idx == '0))
    else $error("tick request did not start the channel walk at channel zero");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && (idx == LAST) |=> (state != ST_WALK))
    else $error("channel walk ran past the last channel");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the finishing step");

  a_program_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_PROGRAM) && ch_ok |=> (state == ST_DONE))
    else $error("program request in range produced no result");

endmodule

`default_nettype wire
